// ----- design/seven_segment_mux_display_unit_assert.svh -----
// Assertion macros for the seven-segment display unit.
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssmd assertion failed");

// Next-cycle implication.
`define SSMD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssmd assertion failed");

`endif

// ----- design/ssmd_pkg.sv -----
// Shared types and constants for the seven-segment display unit.
// Holds the op codes, register indexes, field widths and the segment lookup.
// No dependencies.
package ssmd_pkg;

    localparam int MAX_BOARDS_DEF = 4;
    localparam int DIGITS         = 8;
    localparam int ROW_W          = 3;
    localparam int SP_W           = 5;
    localparam int ADV_W          = 6;
    localparam int CFG_W          = 3;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REFRESH = 2'd2
    } t_op;

    localparam logic CFG_BOARD_CNT = 1'b0;
    localparam logic CFG_REVERSE   = 1'b1;

    localparam logic [7:0] CHAR_FIRST    = 8'h20;
    localparam logic [7:0] CHAR_LAST     = 8'h7E;
    localparam logic [7:0] CHAR_DOT      = 8'h2E;
    localparam logic [7:0] SEG_BLANK     = 8'hFF;
    localparam logic [7:0] SEG_NONE      = 8'h00;
    localparam logic [7:0] DP_CLEAR_MASK = 8'h7F;

    localparam logic [7:0] SEG_TABLE [95] = '{
        8'hFF, 8'hB0, 8'h22, 8'h00, 8'h00, 8'h49, 8'h00, 8'h02,
        8'h4E, 8'h78, 8'h40, 8'h00, 8'h10, 8'h01, 8'h80, 8'h00,
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h48, 8'h58, 8'h00, 8'h09, 8'h00, 8'h65,
        8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h37, 8'h30, 8'h3C, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h7E,
        8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
        8'h00, 8'h27, 8'h6D, 8'h4E, 8'h00, 8'h78, 8'h00, 8'h08,
        8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h17, 8'h10, 8'h3C, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h1D,
        8'h67, 8'h00, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'h00,
        8'h00, 8'h27, 8'h00, 8'h31, 8'h06, 8'h07, 8'h63
    };

    // Printable ASCII goes through the table, anything else gives SEG_NONE.
    function automatic logic [7:0] seg_of(input logic [7:0] ch);
        logic [7:0] ofs;
        ofs = ch - CHAR_FIRST;
        if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
            return SEG_TABLE[ofs[6:0]];
        end
        return SEG_NONE;
    endfunction

endpackage

// ----- design/seven_segment_mux_display_unit.sv -----
// Seven-segment display unit: one digit buffer memory with a scan sequencer.
// Uses ssmd_pkg and the assertion macros in seven_segment_mux_display_unit_assert.svh.
//
// The digit buffer (MAX_BOARDS*8 bytes) lives in one synchronous memory with a
// registered read; per-entry valid flops make an unwritten or cleared entry read
// as 0xFF, so reset and a clear word need not write the memory. A dot reads the
// previous digit and writes it back with the decimal point cleared, and no word
// is taken during the write-back. A refresh word gives (active boards)*8 result
// words, one per cycle from the memory read port while the output is not stalled,
// and the next word is taken once the sequencer is idle and the result stage is
// free. Results pass through one pipeline stage and an output register, so the
// unit keeps working while a finished word waits on a stalled output.
`include "seven_segment_mux_display_unit_assert.svh"

module seven_segment_mux_display_unit #(
    parameter int MAX_BOARDS = ssmd_pkg::MAX_BOARDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_idx,
    input  logic [ssmd_pkg::CFG_W-1:0]  i_cfg_data,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [7:0]                  i_char_code,
    input  logic [ssmd_pkg::SP_W-1:0]   i_start_pos,
    input  logic                        i_first_char,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_segment_byte,
    output logic [7:0]                  o_digit_select,
    output logic                        o_latch,
    output logic                        o_last,
    output logic [ssmd_pkg::ADV_W-1:0]  o_chars_advanced,
    output logic                        o_unknown_char,
    output logic                        o_overflow
);

    localparam int BUF_LEN = MAX_BOARDS * ssmd_pkg::DIGITS;
    localparam int AW      = $clog2(BUF_LEN);
    localparam int CW      = (AW + 1 > ssmd_pkg::ADV_W) ? AW + 1 : ssmd_pkg::ADV_W;
    localparam int NBW     = $clog2(MAX_BOARDS + 1);
    localparam int BW      = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
    localparam int RW      = ssmd_pkg::ROW_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DOT  = 3'b100
    } t_state;

    // configuration
    logic [ssmd_pkg::CFG_W-1:0]  r_board_cnt;
    logic                        r_rev;

    // string state
    logic [CW-1:0]               r_cursor;
    logic [ssmd_pkg::SP_W-1:0]   r_start;
    logic                        r_stopped;

    // sequencer
    t_state                      r_state, n_state;
    logic [RW-1:0]               r_row;
    logic [BW-1:0]               r_board;
    logic [AW-1:0]               r_dot_addr;

    // buffer memory
    logic [7:0]                  r_mem [BUF_LEN];
    logic [BUF_LEN-1:0]          r_vld;
    logic [7:0]                  r_rdata;
    logic                        r_rhit;

    // result stage
    logic                        r_sv;
    logic                        r_s_mem;
    logic [7:0]                  r_s_sel;
    logic                        r_s_latch;
    logic                        r_s_last;
    logic [ssmd_pkg::ADV_W-1:0]  r_s_adv;
    logic                        r_s_unk;
    logic                        r_s_ovf;

    // output register
    logic                        r_ov;
    logic [7:0]                  r_o_seg;
    logic [7:0]                  r_o_sel;
    logic                        r_o_latch;
    logic                        r_o_last;
    logic [ssmd_pkg::ADV_W-1:0]  r_o_adv;
    logic                        r_o_unk;
    logic                        r_o_ovf;

    logic [NBW-1:0]              nb;
    logic [BW-1:0]               nb_m1;
    logic [CW-1:0]               limit;

    logic                        out_free, s_move, s_free, acc;
    logic                        acc_wr, acc_clr, acc_ref;

    logic [CW-1:0]               cur0, cur_dec, wr_cur;
    logic [ssmd_pkg::SP_W-1:0]   start0;
    logic                        stop0, wr_stop, wr_we, dot_go, is_dot;
    logic [7:0]                  wr_seg;
    logic [CW-1:0]               wr_diff;

    logic                        scan_issue, scan_latch, scan_last;
    logic [BW-1:0]               scan_board;
    logic [AW-1:0]               scan_idx;
    logic [7:0]                  onehot, scan_sel;

    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_wa, mem_ra;
    logic [7:0]                  mem_wd;

    // active board count, clamped to 1..MAX_BOARDS
    always_comb begin
        if (r_board_cnt == '0) begin
            nb = NBW'(1);
        end else if (int'(r_board_cnt) > MAX_BOARDS) begin
            nb = NBW'(MAX_BOARDS);
        end else begin
            nb = NBW'(r_board_cnt);
        end
    end

    assign nb_m1 = BW'(nb - NBW'(1));
    assign limit = CW'({nb, 3'b000});

    // handshake
    assign out_free = !r_ov || !i_stall;
    assign s_move   = r_sv && out_free;
    assign s_free   = !r_sv || out_free;
    assign o_stall  = !((r_state == ST_IDLE) && s_free);
    assign acc      = i_valid && !o_stall;
    assign acc_clr  = acc && (i_op == ssmd_pkg::OP_CLEAR);
    assign acc_wr   = acc && (i_op == ssmd_pkg::OP_WRITE);
    assign acc_ref  = acc && (i_op == ssmd_pkg::OP_REFRESH);

    // character write decode
    always_comb begin
        cur0    = i_first_char ? CW'(i_start_pos) : r_cursor;
        start0  = i_first_char ? i_start_pos : r_start;
        stop0   = i_first_char ? 1'b0 : r_stopped;
        wr_seg  = ssmd_pkg::seg_of(i_char_code);
        is_dot  = (i_char_code == ssmd_pkg::CHAR_DOT);
        cur_dec = (cur0 != CW'(start0)) ? cur0 - CW'(1) : cur0;
        wr_cur  = cur0;
        wr_stop = stop0;
        wr_we   = 1'b0;
        dot_go  = 1'b0;
        if (!stop0) begin
            if (is_dot) begin
                // a dot past the active digits changes nothing but the cursor
                dot_go = (cur_dec < limit);
                wr_cur = cur_dec + CW'(1);
            end else if (cur0 >= limit) begin
                wr_stop = 1'b1;
            end else begin
                wr_we  = 1'b1;
                wr_cur = cur0 + CW'(1);
            end
        end
        wr_diff = wr_cur - CW'(start0);
    end

    // scan addressing: row-major, boards optionally reversed
    always_comb begin
        scan_issue = (r_state == ST_SCAN) && s_free;
        scan_latch = (r_board == nb_m1);
        scan_last  = scan_latch && (r_row == RW'(ssmd_pkg::DIGITS - 1));
        scan_board = r_rev ? BW'(nb_m1 - r_board) : r_board;
        scan_idx   = AW'({scan_board, r_row});
        onehot     = 8'(1) << r_row;
        scan_sel   = {onehot[3:0], onehot[7:4]};
    end

    // memory port control
    always_comb begin
        mem_we = (acc_wr && wr_we) || (r_state == ST_DOT);
        mem_wa = (r_state == ST_DOT) ? r_dot_addr : AW'(cur0);
        if (r_state == ST_DOT) begin
            mem_wd = r_rhit ? (r_rdata & ssmd_pkg::DP_CLEAR_MASK) : ssmd_pkg::DP_CLEAR_MASK;
        end else begin
            mem_wd = wr_seg;
        end
        mem_re = scan_issue || (acc_wr && dot_go);
        mem_ra = scan_issue ? scan_idx : AW'(cur_dec);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
            r_rhit  <= r_vld[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (acc_clr) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_wa] <= 1'b1;
        end
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_ref) begin
                    n_state = ST_SCAN;
                end else if (acc_wr && dot_go) begin
                    n_state = ST_DOT;
                end
            end
            ST_SCAN: begin
                if (scan_issue && scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DOT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_board_cnt <= ssmd_pkg::CFG_W'(1);
            r_rev       <= 1'b0;
            r_cursor    <= '0;
            r_start     <= '0;
            r_stopped   <= 1'b0;
            r_row       <= '0;
            r_board     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    ssmd_pkg::CFG_BOARD_CNT: r_board_cnt <= i_cfg_data;
                    ssmd_pkg::CFG_REVERSE:   r_rev       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (acc_wr) begin
                r_cursor  <= wr_cur;
                r_start   <= start0;
                r_stopped <= wr_stop;
            end
            if (acc_ref) begin
                r_row   <= '0;
                r_board <= '0;
            end else if (scan_issue) begin
                // advance board, then row at the end of each row
                if (scan_latch) begin
                    r_board <= '0;
                    r_row   <= r_row + RW'(1);
                end else begin
                    r_board <= r_board + BW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_wr && dot_go) begin
            r_dot_addr <= AW'(cur_dec);
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (scan_issue || acc_wr) begin
            r_sv <= 1'b1;
        end else if (s_move) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_s_mem   <= 1'b1;
            r_s_sel   <= scan_sel;
            r_s_latch <= scan_latch;
            r_s_last  <= scan_last;
            r_s_adv   <= '0;
            r_s_unk   <= 1'b0;
            r_s_ovf   <= 1'b0;
        end else if (acc_wr) begin
            r_s_mem   <= 1'b0;
            r_s_sel   <= 8'h00;
            r_s_latch <= 1'b0;
            r_s_last  <= 1'b1;
            r_s_adv   <= ssmd_pkg::ADV_W'(wr_diff);
            r_s_unk   <= (wr_seg == ssmd_pkg::SEG_NONE);
            r_s_ovf   <= wr_stop;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s_move) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_move) begin
            if (r_s_mem) begin
                r_o_seg <= r_rhit ? r_rdata : ssmd_pkg::SEG_BLANK;
            end else begin
                r_o_seg <= ssmd_pkg::SEG_NONE;
            end
            r_o_sel   <= r_s_sel;
            r_o_latch <= r_s_latch;
            r_o_last  <= r_s_last;
            r_o_adv   <= r_s_adv;
            r_o_unk   <= r_s_unk;
            r_o_ovf   <= r_s_ovf;
        end
    end

    assign o_valid          = r_ov;
    assign o_segment_byte   = r_o_seg;
    assign o_digit_select   = r_o_sel;
    assign o_latch          = r_o_latch;
    assign o_last           = r_o_last;
    assign o_chars_advanced = r_o_adv;
    assign o_unknown_char   = r_o_unk;
    assign o_overflow       = r_o_ovf;

    `SSMD_ASSERT_NXT(a_dot_writeback_one_cycle, r_state == ST_DOT, r_state == ST_IDLE)
    `SSMD_ASSERT_NXT(a_scan_ends_on_last, scan_issue && scan_last, r_state == ST_IDLE)
    `SSMD_ASSERT_NXT(a_write_gives_result, acc_wr, r_sv && r_s_last && !r_s_mem)
    `SSMD_ASSERT_IMP(a_board_in_range, r_state == ST_SCAN, r_board <= nb_m1)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for seven_segment_mux_display_unit: directed and random words
// against a behavioral model of the digit buffer and scan order. Depends on ssmd_pkg.
module tb_top;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned BUF_DEPTH     = ssmd_pkg::MAX_BOARDS_DEF * ssmd_pkg::DIGITS;
    localparam int          ADDR_W        = $clog2(BUF_DEPTH);

    localparam logic [7:0] GLYPH_ROM [95] = '{
        8'hFF, 8'hB0, 8'h22, 8'h00, 8'h00, 8'h49, 8'h00, 8'h02,
        8'h4E, 8'h78, 8'h40, 8'h00, 8'h10, 8'h01, 8'h80, 8'h00,
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h48, 8'h58, 8'h00, 8'h09, 8'h00, 8'h65,
        8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h37, 8'h30, 8'h3C, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h7E,
        8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
        8'h00, 8'h27, 8'h6D, 8'h4E, 8'h00, 8'h78, 8'h00, 8'h08,
        8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h17, 8'h10, 8'h3C, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h1D,
        8'h67, 8'h00, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'h00,
        8'h00, 8'h27, 8'h00, 8'h31, 8'h06, 8'h07, 8'h63
    };

    localparam logic [2:0] SWEEP_BOARDS [8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd0, 3'd7, 3'd5};
    localparam logic       SWEEP_REV    [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef struct packed {
        logic [7:0]                 seg;
        logic [7:0]                 sel;
        logic                       latch;
        logic                       last;
        logic [ssmd_pkg::ADV_W-1:0] adv;
        logic                       unk;
        logic                       ovf;
    } t_disp_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic                         i_cfg_idx;
    logic [ssmd_pkg::CFG_W-1:0]   i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic [1:0]                   i_op;
    logic [7:0]                   i_char_code;
    logic [ssmd_pkg::SP_W-1:0]    i_start_pos;
    logic                         i_first_char;
    logic                         o_valid;
    logic                         i_stall;
    logic [7:0]                   o_segment_byte;
    logic [7:0]                   o_digit_select;
    logic                         o_latch;
    logic                         o_last;
    logic [ssmd_pkg::ADV_W-1:0]   o_chars_advanced;
    logic                         o_unknown_char;
    logic                         o_overflow;

    // Model state and register copies
    logic [7:0]                 m_digits [BUF_DEPTH] = '{default: ssmd_pkg::SEG_BLANK};
    logic [ssmd_pkg::ADV_W-1:0] m_cursor  = '0;
    logic [ssmd_pkg::SP_W-1:0]  m_start   = '0;
    logic                       m_stopped = 1'b0;
    logic [ssmd_pkg::CFG_W-1:0] m_boards  = 3'd1;
    logic                       m_reverse = 1'b0;

    t_disp_result pending_display_results [$];
    int unsigned  error_count  = 0;
    int unsigned  words_sent   = 0;
    int unsigned  cycle_count  = 0;
    bit           idle_on      = 1'b1;
    bit           hold_request = 1'b0;

    seven_segment_mux_display_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_char_code      (i_char_code),
        .i_start_pos      (i_start_pos),
        .i_first_char     (i_first_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_segment_byte   (o_segment_byte),
        .o_digit_select   (o_digit_select),
        .o_latch          (o_latch),
        .o_last           (o_last),
        .o_chars_advanced (o_chars_advanced),
        .o_unknown_char   (o_unknown_char),
        .o_overflow       (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned boards_in_use();
        if (m_boards == 3'd0) return 1;
        if (m_boards > ssmd_pkg::MAX_BOARDS_DEF) return ssmd_pkg::MAX_BOARDS_DEF;
        return m_boards;
    endfunction

    // Update the model for one accepted word and queue the words it produces.
    task automatic predict_display_words(input logic [1:0] op, input logic [7:0] ch,
                                         input logic [ssmd_pkg::SP_W-1:0] sp,
                                         input logic first);
        int unsigned  nb;
        int unsigned  lim;
        int unsigned  row;
        int unsigned  j;
        int unsigned  board;
        logic [7:0]   glyph;
        logic [7:0]   onehot;
        t_disp_result r;
        nb  = boards_in_use();
        lim = nb * ssmd_pkg::DIGITS;
        r   = '0;
        if (op == ssmd_pkg::OP_CLEAR) begin
            for (j = 0; j < BUF_DEPTH; j++) m_digits[ADDR_W'(j)] = ssmd_pkg::SEG_BLANK;
        end else if (op == ssmd_pkg::OP_WRITE) begin
            if (first) begin
                m_cursor  = {1'b0, sp};
                m_start   = sp;
                m_stopped = 1'b0;
            end
            glyph = ssmd_pkg::SEG_NONE;
            if (ch >= ssmd_pkg::CHAR_FIRST && ch <= ssmd_pkg::CHAR_LAST) begin
                glyph = GLYPH_ROM[7'(ch - ssmd_pkg::CHAR_FIRST)];
            end
            if (!m_stopped) begin
                if (ch == ssmd_pkg::CHAR_DOT) begin
                    // step back onto the previous digit, drop its point, step forward
                    if (m_cursor != {1'b0, m_start}) m_cursor = m_cursor - 1'b1;
                    if (m_cursor < lim) begin
                        m_digits[ADDR_W'(m_cursor)] = m_digits[ADDR_W'(m_cursor)]
                                                      & ssmd_pkg::DP_CLEAR_MASK;
                    end
                    m_cursor = m_cursor + 1'b1;
                end else if (m_cursor >= lim) begin
                    m_stopped = 1'b1;
                end else begin
                    m_digits[ADDR_W'(m_cursor)] = glyph;
                    m_cursor = m_cursor + 1'b1;
                end
            end
            r.last = 1'b1;
            r.adv  = m_cursor - {1'b0, m_start};
            r.unk  = (glyph == ssmd_pkg::SEG_NONE);
            r.ovf  = m_stopped;
            pending_display_results.push_back(r);
        end else if (op == ssmd_pkg::OP_REFRESH) begin
            for (row = 0; row < ssmd_pkg::DIGITS; row++) begin
                onehot = 8'd1 << row;
                for (j = 0; j < nb; j++) begin
                    board   = m_reverse ? (nb - 1 - j) : j;
                    r       = '0;
                    r.seg   = m_digits[ADDR_W'(board * ssmd_pkg::DIGITS + row)];
                    r.sel   = {onehot[3:0], onehot[7:4]};
                    r.latch = (j == nb - 1);
                    r.last  = r.latch && (row == ssmd_pkg::DIGITS - 1);
                    pending_display_results.push_back(r);
                end
            end
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [ssmd_pkg::SP_W-1:0] sp, input logic first);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_char_code  <= ch;
        i_start_pos  <= sp;
        i_first_char <= first;
        do @(posedge i_clk); while (o_stall);
        predict_display_words(op, ch, sp, first);
        if (op != OP_UNUSED) words_sent++;
    endtask

    // Drop valid, wait for every predicted word, then let in-flight work finish.
    task automatic drain_outputs();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_display_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ssmd_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == ssmd_pkg::CFG_BOARD_CNT) m_boards = data;
        else m_reverse = data[0];
    endtask

    task automatic set_display(input logic [ssmd_pkg::CFG_W-1:0] boards, input logic rev);
        drain_outputs();
        write_reg(ssmd_pkg::CFG_BOARD_CNT, boards);
        write_reg(ssmd_pkg::CFG_REVERSE, {2'($urandom_range(0, 3)), rev});
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2) return ssmd_pkg::CHAR_DOT;
        if (r == 2) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(ssmd_pkg::CHAR_FIRST, ssmd_pkg::CHAR_LAST));
    endfunction

    task automatic send_string(input logic [ssmd_pkg::SP_W-1:0] sp, input int unsigned len);
        int unsigned n;
        for (n = 0; n < len; n++) begin
            send_item(ssmd_pkg::OP_WRITE, pick_char(),
                      (n == 0) ? sp : 5'($urandom_range(0, 31)), n == 0);
        end
    endtask

    task automatic send_random_word();
        int unsigned pick;
        int unsigned lim;
        logic [ssmd_pkg::SP_W-1:0] sp;
        pick = $urandom_range(0, 99);
        lim  = boards_in_use() * ssmd_pkg::DIGITS;
        sp   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, lim - 1));
        if (pick < 60) begin
            send_string(sp, $urandom_range(1, 12));
        end else if (pick < 80) begin
            send_item(ssmd_pkg::OP_REFRESH, 8'($urandom), 5'($urandom), 1'($urandom));
        end else if (pick < 85) begin
            send_item(ssmd_pkg::OP_CLEAR, 8'($urandom), 5'($urandom), 1'($urandom));
        end else if (pick < 88) begin
            send_item(OP_UNUSED, 8'($urandom), 5'($urandom), 1'($urandom));
        end else begin
            send_item(2'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_reset_contents();
        send_item(ssmd_pkg::OP_REFRESH, 8'h00, 5'd0, 1'b0);
    endtask

    task automatic test_character_extremes();
        send_item(ssmd_pkg::OP_WRITE, 8'h41, 5'd0, 1'b1);
        send_item(ssmd_pkg::OP_WRITE, 8'h00, 5'd31, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'hFF, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'h7F, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'h1F, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_LAST, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_FIRST, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_DOT, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'h5A, 5'd0, 1'b0);
        // runs past the last digit and sets overflow; the dot after it changes nothing
        send_item(ssmd_pkg::OP_WRITE, 8'h78, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_DOT, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_REFRESH, 8'hFF, 5'd31, 1'b1);
    endtask

    task automatic test_dot_handling();
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_DOT, 5'd3, 1'b1);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_DOT, 5'd31, 1'b1);
        send_item(ssmd_pkg::OP_WRITE, ssmd_pkg::CHAR_DOT, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'h38, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_WRITE, 8'h31, 5'd31, 1'b1);
        send_item(ssmd_pkg::OP_REFRESH, 8'h00, 5'd0, 1'b0);
        send_item(ssmd_pkg::OP_CLEAR, 8'hFF, 5'd31, 1'b1);
        send_item(OP_UNUSED, 8'hFF, 5'd31, 1'b1);
        send_item(ssmd_pkg::OP_REFRESH, 8'h00, 5'd0, 1'b0);
    endtask

    task automatic test_board_settings();
        int unsigned k;
        for (k = 0; k < 8; k++) begin
            set_display(SWEEP_BOARDS[k], SWEEP_REV[k]);
            send_string(5'd0, boards_in_use() * ssmd_pkg::DIGITS + 2);
            send_item(ssmd_pkg::OP_REFRESH, 8'($urandom), 5'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        while (words_sent < 350) begin
            if ($urandom_range(0, 19) == 0) begin
                set_display(3'($urandom_range(0, 7)), 1'($urandom));
            end
            send_random_word();
        end
    endtask

    task automatic test_output_backpressure();
        int unsigned k;
        set_display(3'd4, 1'($urandom));
        hold_request = 1'b1;
        for (k = 0; k < 6; k++) begin
            send_item(ssmd_pkg::OP_REFRESH, 8'($urandom), 5'($urandom), 1'($urandom));
            send_string(5'($urandom_range(0, 31)), 2);
        end
        // sender pauses here until the output side has caught up
        drain_outputs();
        send_string(5'($urandom_range(0, 31)), 4);
        send_item(ssmd_pkg::OP_REFRESH, 8'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic test_full_rate();
        int unsigned k;
        set_display(3'($urandom_range(1, 4)), 1'($urandom));
        idle_on = 1'b0;
        for (k = 0; k < 25; k++) send_random_word();
    endtask

    // Receiver side: random stall bursts, quiet runs, and one long hold on request.
    initial begin
        int unsigned burst_left;
        int unsigned run_left;
        int unsigned hold_left;
        logic        stall_next;
        burst_left = 0;
        run_left   = 0;
        hold_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                stall_next = 1'b1;
            end else if (run_left > 0 || !idle_on) begin
                if (run_left > 0) run_left--;
                stall_next = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                burst_left = $urandom_range(1, 18) - 1;
                stall_next = 1'b1;
            end else begin
                run_left   = $urandom_range(1, 40);
                stall_next = 1'b0;
            end
            i_stall <= stall_next;
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_disp_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_display_results.size() == 0) begin
                $error("output word with nothing predicted");
                error_count++;
            end else begin
                exp_r = pending_display_results.pop_front();
                check_field("segment_byte", exp_r.seg, o_segment_byte);
                check_field("digit_select", exp_r.sel, o_digit_select);
                check_field("latch", 8'(exp_r.latch), 8'(o_latch));
                check_field("last", 8'(exp_r.last), 8'(o_last));
                check_field("chars_advanced", 8'(exp_r.adv), 8'(o_chars_advanced));
                check_field("unknown_char", 8'(exp_r.unk), 8'(o_unknown_char));
                check_field("overflow", 8'(exp_r.ovf), 8'(o_overflow));
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_idx    = ssmd_pkg::CFG_BOARD_CNT;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_op         = ssmd_pkg::OP_CLEAR;
        i_char_code  = '0;
        i_start_pos  = '0;
        i_first_char = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_character_extremes();
        test_dot_handling();
        test_board_settings();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();

        drain_outputs();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/ssmd_pkg.sv
design/seven_segment_mux_display_unit.sv
test/tb_top.sv
